// File: hw/rtl/dkq_pkg.sv
package dkq_pkg;

    // Field widths of the request and response beats.
    localparam int CMD_W    = 2;
    localparam int DAY_W    = 5;
    localparam int MONTH_W  = 4;
    localparam int KEY_W    = 14;
    localparam int STATUS_W = 3;
    localparam int REC_W    = 8;
    localparam int SLOT_W   = 4;

    // The record counter is one bit wider than a stored record number.
    localparam int CNT_W = 9;

    // Default sizes of the table.
    localparam int TABLE_SIZE_DEF  = 16;
    localparam int MAX_RECORDS_DEF = 256;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NO_SLOT   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_LIMIT     = 3'd4;

    // One slot of the table as it sits in memory.
    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] key;
        logic [REC_W-1:0] rec;
    } slot_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_PROBE,
        ST_WIPE,
        ST_RESP
    } state_t;

endpackage

// File: hw/rtl/dkq_ram.sv
module dkq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one read port with registered data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        rdata_reg <= ram_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/date_key_quadratic_probe_table.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  command, day, month, year
// rsp       out        rsp_valid / rsp_ready  status, record_number, slot_index
//
// One request at a time. Insert and search run a two-step key mod TABLE_SIZE by
// reciprocal multiplication, then one slot read per cycle from the single-port-read
// table memory. Clear writes every slot; an insert at the record limit or an unused
// command goes straight to the response.
// After reset a clearing pass over all TABLE_SIZE slots runs before the first request.
// A waiting response does not block acceptance of the next request.
module date_key_quadratic_probe_table #(
    parameter int TABLE_SIZE  = dkq_pkg::TABLE_SIZE_DEF,
    parameter int MAX_RECORDS = dkq_pkg::MAX_RECORDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [dkq_pkg::CMD_W-1:0]     command,
    input  logic [dkq_pkg::DAY_W-1:0]     day,
    input  logic [dkq_pkg::MONTH_W-1:0]   month,
    input  logic [dkq_pkg::KEY_W-1:0]     year,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [dkq_pkg::STATUS_W-1:0]  status,
    output logic [dkq_pkg::REC_W-1:0]     record_number,
    output logic [dkq_pkg::SLOT_W-1:0]    slot_index
);

    import dkq_pkg::*;

    localparam int IDX_W   = $clog2(TABLE_SIZE);
    localparam int SUM_W   = IDX_W + 1;
    localparam logic [SUM_W-1:0] N_S = SUM_W'(TABLE_SIZE);

    // Reciprocal of the table size, exact for every key of KEY_W bits.
    localparam int MUL_S   = KEY_W + IDX_W;
    localparam int PROD_W  = 2 * KEY_W + 1;
    localparam int RECIP_I = ((1 << MUL_S) + TABLE_SIZE - 1) / TABLE_SIZE;
    localparam logic [PROD_W-1:0] RECIP_P = PROD_W'(RECIP_I);
    localparam logic [KEY_W-1:0]  N_K     = KEY_W'(TABLE_SIZE);

    state_t state_reg, state_next;

    logic                req_acc;
    logic [KEY_W-1:0]    key_sum;
    logic                srch_reg, srch_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [KEY_W-1:0]    quo_reg, quo_next;
    logic                mod_cnt_reg, mod_cnt_next;
    logic [IDX_W-1:0]    rem_reg, rem_next;
    logic [IDX_W-1:0]    off_reg, off_next;
    logic [IDX_W-1:0]    delta_reg, delta_next;
    logic [SUM_W-1:0]    pcnt_reg, pcnt_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]    rd_slot_reg, rd_slot_next;
    logic [IDX_W-1:0]    wipe_cnt_reg, wipe_cnt_next;
    logic                wipe_reply_reg, wipe_reply_next;
    logic [CNT_W-1:0]    next_rec_reg, next_rec_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [REC_W-1:0]    res_rec_reg, res_rec_next;
    logic [IDX_W-1:0]    res_slot_reg, res_slot_next;
    logic                rsp_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [REC_W-1:0]    record_number_reg;
    logic [SLOT_W-1:0]   slot_index_reg;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    slot_t               ram_wdata;
    slot_t               rd_word;

    logic                at_limit;
    logic                slot_empty;
    logic                key_hit;
    logic                probe_stop;
    logic                probe_fail;
    logic                issue;
    logic                wipe_last;
    logic                rsp_load;
    logic [SUM_W-1:0]    slot_sum;
    logic [IDX_W-1:0]    probe_slot;
    logic [SUM_W-1:0]    off_sum;
    logic [SUM_W-1:0]    delta_sum;
    logic [PROD_W-1:0]   quo_prod;
    logic [KEY_W-1:0]    quo_new;
    logic [KEY_W-1:0]    rem_full;
    logic [IDX_W-1:0]    rem_new;

    // Table memory: used flag, key and record number per slot.
    dkq_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (probe_slot),
        .rdata (rd_word)
    );

    assign req_acc  = req_valid && req_ready;
    assign key_sum  = KEY_W'(day) + KEY_W'(month) + year;
    assign at_limit = (next_rec_reg >= CNT_W'(MAX_RECORDS));

    // Key mod table size: the quotient is registered first, then the remainder from it.
    assign quo_prod = PROD_W'(key_reg) * RECIP_P;
    assign quo_new  = KEY_W'(quo_prod >> MUL_S);
    assign rem_full = key_reg - quo_reg * N_K;
    assign rem_new  = IDX_W'(rem_full);

    // Probe address: base plus squared offset, both already below the table size.
    assign slot_sum   = {1'b0, rem_reg} + {1'b0, off_reg};
    assign probe_slot = (slot_sum >= N_S) ? IDX_W'(slot_sum - N_S) : IDX_W'(slot_sum);

    // The squared offset advances by 2p+1, kept modulo the table size.
    assign off_sum   = {1'b0, off_reg} + {1'b0, delta_reg};
    assign delta_sum = {1'b0, delta_reg} + SUM_W'(2);

    // Evaluation of the slot read in the previous cycle.
    assign slot_empty = !rd_word.used;
    assign key_hit    = (rd_word.key == key_reg);
    assign probe_stop = rd_pend_reg && (slot_empty || (srch_reg && key_hit));
    assign probe_fail = rd_pend_reg && !probe_stop && (pcnt_reg == N_S);
    assign issue      = (state_reg == ST_PROBE) && !probe_stop && (pcnt_reg != N_S);

    assign wipe_last = (wipe_cnt_reg == IDX_W'(TABLE_SIZE - 1));
    assign rsp_load  = (state_reg == ST_RESP) && (!rsp_valid_reg || rsp_ready);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    unique case (command)
                        CMD_CLEAR:  state_next = ST_WIPE;
                        CMD_INSERT: state_next = at_limit ? ST_RESP : ST_MOD;
                        CMD_SEARCH: state_next = ST_MOD;
                        default:    state_next = ST_RESP;
                    endcase
                end
            end
            ST_MOD:
            begin
                if (mod_cnt_reg)
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (probe_stop || probe_fail)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_WIPE:
            begin
                if (wipe_last)
                begin
                    state_next = wipe_reply_reg ? ST_RESP : ST_IDLE;
                end
            end
            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake and memory write controls.
    always_comb
    begin
        req_ready = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = rd_slot_reg;
        ram_wdata = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            ST_WIPE:
            begin
                ram_we    = 1'b1;
                ram_waddr = wipe_cnt_reg;
            end
            ST_PROBE:
            begin
                ram_we         = probe_stop && slot_empty && !srch_reg;
                ram_wdata.used = 1'b1;
                ram_wdata.key  = key_reg;
                ram_wdata.rec  = next_rec_reg[REC_W-1:0];
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        srch_next       = srch_reg;
        key_next        = key_reg;
        quo_next        = quo_reg;
        mod_cnt_next    = mod_cnt_reg;
        rem_next        = rem_reg;
        off_next        = off_reg;
        delta_next      = delta_reg;
        pcnt_next       = pcnt_reg;
        rd_pend_next    = 1'b0;
        rd_slot_next    = rd_slot_reg;
        wipe_cnt_next   = wipe_cnt_reg;
        wipe_reply_next = wipe_reply_reg;
        next_rec_next   = next_rec_reg;
        res_status_next = res_status_reg;
        res_rec_next    = res_rec_reg;
        res_slot_next   = res_slot_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_acc)
                begin
                    srch_next       = (command == CMD_SEARCH);
                    key_next        = key_sum;
                    mod_cnt_next    = 1'b0;
                    rem_next        = '0;
                    off_next        = '0;
                    delta_next      = IDX_W'(1);
                    pcnt_next       = '0;
                    res_rec_next    = '0;
                    res_slot_next   = '0;
                    res_status_next = STAT_NOT_FOUND;
                    unique case (command)
                        CMD_CLEAR:
                        begin
                            wipe_cnt_next   = '0;
                            wipe_reply_next = 1'b1;
                            next_rec_next   = '0;
                            res_status_next = STAT_OK;
                        end
                        CMD_INSERT:
                        begin
                            res_status_next = STAT_LIMIT;
                        end
                        CMD_SEARCH:
                        begin
                            res_status_next = STAT_NOT_FOUND;
                        end
                        default:
                        begin
                            res_status_next = STAT_NOT_FOUND;
                        end
                    endcase
                end
            end
            ST_MOD:
            begin
                if (mod_cnt_reg)
                begin
                    rem_next = rem_new;
                end
                else
                begin
                    quo_next = quo_new;
                end
                mod_cnt_next = !mod_cnt_reg;
            end
            ST_PROBE:
            begin
                rd_pend_next = issue;
                if (issue)
                begin
                    rd_slot_next = probe_slot;
                    off_next     = (off_sum >= N_S) ? IDX_W'(off_sum - N_S) : IDX_W'(off_sum);
                    delta_next   = (delta_sum >= N_S) ? IDX_W'(delta_sum - N_S)
                                                      : IDX_W'(delta_sum);
                    pcnt_next    = pcnt_reg + SUM_W'(1);
                end
                if (probe_stop)
                begin
                    if (srch_reg && !slot_empty)
                    begin
                        res_status_next = STAT_FOUND;
                        res_rec_next    = rd_word.rec;
                        res_slot_next   = rd_slot_reg;
                    end
                    else if (srch_reg)
                    begin
                        res_status_next = STAT_NOT_FOUND;
                    end
                    else
                    begin
                        res_status_next = STAT_OK;
                        res_rec_next    = next_rec_reg[REC_W-1:0];
                        res_slot_next   = rd_slot_reg;
                        next_rec_next   = next_rec_reg + CNT_W'(1);
                    end
                end
                else if (probe_fail)
                begin
                    res_status_next = srch_reg ? STAT_NOT_FOUND : STAT_NO_SLOT;
                end
            end
            ST_WIPE:
            begin
                wipe_cnt_next = wipe_cnt_reg + IDX_W'(1);
            end
            default:
            begin
                rd_pend_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_WIPE;
            mod_cnt_reg    <= 1'b0;
            pcnt_reg       <= '0;
            rd_pend_reg    <= 1'b0;
            wipe_cnt_reg   <= '0;
            wipe_reply_reg <= 1'b0;
            next_rec_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mod_cnt_reg    <= mod_cnt_next;
            pcnt_reg       <= pcnt_next;
            rd_pend_reg    <= rd_pend_next;
            wipe_cnt_reg   <= wipe_cnt_next;
            wipe_reply_reg <= wipe_reply_next;
            next_rec_reg   <= next_rec_next;
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        srch_reg       <= srch_next;
        key_reg        <= key_next;
        quo_reg        <= quo_next;
        rem_reg        <= rem_next;
        off_reg        <= off_next;
        delta_reg      <= delta_next;
        rd_slot_reg    <= rd_slot_next;
        res_status_reg <= res_status_next;
        res_rec_reg    <= res_rec_next;
        res_slot_reg   <= res_slot_next;
        if (rsp_load)
        begin
            status_reg        <= res_status_reg;
            record_number_reg <= res_rec_reg;
            slot_index_reg    <= SLOT_W'(res_slot_reg);
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign record_number = record_number_reg;
    assign slot_index    = slot_index_reg;

`ifndef NO_ASSERTIONS
    // The table is written only by the clearing pass or at the end of an insert.
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_WIPE || state_reg == ST_PROBE))
        else $error("table write outside clear or probe");

    // The record counter never passes the record limit.
    a_rec_limit: assert property (@(posedge clk) disable iff (!rst_n)
        next_rec_reg <= CNT_W'(MAX_RECORDS))
        else $error("record counter beyond limit");

    // Hash base and probe offset stay inside the table while probing.
    a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> ({1'b0, rem_reg} < N_S && {1'b0, off_reg} < N_S))
        else $error("probe address term out of range");

    // A response appears only after the response state.
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_RESP))
        else $error("response raised outside response state");

    // No more probes are issued than the table has slots.
    a_probe_count: assert property (@(posedge clk) disable iff (!rst_n)
        pcnt_reg <= N_S)
        else $error("probe count beyond table size");
`endif

endmodule

// File: tb/date_key_quadratic_probe_table_tb.sv
module date_key_quadratic_probe_table_tb;

    import dkq_pkg::*;

    localparam int N_ITEMS     = 1300;
    localparam int CALM_FROM   = N_ITEMS - N_ITEMS / 10;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;
    localparam int POOL_MAX    = 8;

    // The fourth command code has no meaning; the table must answer not found.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Expected answer of the table and a model of its contents.
    class date_table_scoreboard;

        typedef struct {
            logic [STATUS_W-1:0] status;
            logic [REC_W-1:0]    rec;
            logic [SLOT_W-1:0]   slot;
        } answer_t;

        bit                used [TABLE_SIZE_DEF];
        logic [KEY_W-1:0]  keys [TABLE_SIZE_DEF];
        logic [REC_W-1:0]  recs [TABLE_SIZE_DEF];
        logic [CNT_W-1:0]  next_rec;
        answer_t           pending [$];
        int                errors;

        function new();
            foreach (used[i])
            begin
                used[i] = 1'b0;
            end
            next_rec = '0;
            errors   = 0;
        endfunction

        // Work out the answer to one accepted request beat and update the model.
        function void note_request(logic [CMD_W-1:0] cmd, logic [DAY_W-1:0] d,
                                   logic [MONTH_W-1:0] m, logic [KEY_W-1:0] y);
            logic [KEY_W-1:0] key;
            answer_t          ans;
            int               j;
            bit               done;

            key  = KEY_W'(d) + KEY_W'(m) + y;
            ans  = '{STAT_NOT_FOUND, '0, '0};
            done = 1'b0;
            if (cmd == CMD_CLEAR)
            begin
                foreach (used[i])
                begin
                    used[i] = 1'b0;
                end
                next_rec = '0;
                ans      = '{STAT_OK, '0, '0};
            end
            else if (cmd == CMD_INSERT)
            begin
                if (next_rec >= CNT_W'(MAX_RECORDS_DEF))
                begin
                    ans = '{STAT_LIMIT, '0, '0};
                end
                else
                begin
                    ans = '{STAT_NO_SLOT, '0, '0};
                    for (int p = 0; p < TABLE_SIZE_DEF && !done; p++)
                    begin
                        j = (int'(key) % TABLE_SIZE_DEF + (p * p) % TABLE_SIZE_DEF)
                            % TABLE_SIZE_DEF;
                        if (!used[j])
                        begin
                            used[j]  = 1'b1;
                            keys[j]  = key;
                            recs[j]  = next_rec[REC_W-1:0];
                            ans      = '{STAT_OK, next_rec[REC_W-1:0], SLOT_W'(j)};
                            next_rec = next_rec + CNT_W'(1);
                            done     = 1'b1;
                        end
                    end
                end
            end
            else if (cmd == CMD_SEARCH)
            begin
                // Stop at the first empty slot, or give up after a full probe run.
                for (int p = 0; p < TABLE_SIZE_DEF && !done; p++)
                begin
                    j = (int'(key) % TABLE_SIZE_DEF + (p * p) % TABLE_SIZE_DEF)
                        % TABLE_SIZE_DEF;
                    if (!used[j])
                    begin
                        done = 1'b1;
                    end
                    else if (keys[j] == key)
                    begin
                        ans  = '{STAT_FOUND, recs[j], SLOT_W'(j)};
                        done = 1'b1;
                    end
                end
            end
            pending.push_back(ans);
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
            errors++;
        endtask

        // Compare one accepted response beat with the oldest expected answer.
        task check_response(logic [STATUS_W-1:0] st, logic [REC_W-1:0] rec,
                            logic [SLOT_W-1:0] slot);
            answer_t want;

            if (pending.size() == 0)
            begin
                report_mismatch("response beat with no request waiting", int'(st), -1);
            end
            else
            begin
                want = pending.pop_front();
                if (st !== want.status)
                    report_mismatch("status", int'(st), int'(want.status));
                if (rec !== want.rec)
                    report_mismatch("record_number", int'(rec), int'(want.rec));
                if (slot !== want.slot)
                    report_mismatch("slot_index", int'(slot), int'(want.slot));
            end
        endtask

    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    logic [CMD_W-1:0]     command = CMD_CLEAR;
    logic [DAY_W-1:0]     day = '0;
    logic [MONTH_W-1:0]   month = '0;
    logic [KEY_W-1:0]     year = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [REC_W-1:0]     record_number;
    logic [SLOT_W-1:0]    slot_index;

    date_table_scoreboard sb = new();
    int                   sent = 0;
    bit                   calm = 1'b0;
    int                   cycles = 0;

    logic [DAY_W-1:0]     pool_day   [POOL_MAX];
    logic [MONTH_W-1:0]   pool_month [POOL_MAX];
    logic [KEY_W-1:0]     pool_year  [POOL_MAX];

    date_key_quadratic_probe_table dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_ready     (req_ready),
        .command       (command),
        .day           (day),
        .month         (month),
        .year          (year),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .status        (status),
        .record_number (record_number),
        .slot_index    (slot_index)
    );

    always #10 clk = ~clk;

    // Reset is held low from the start and released on a falling edge.
    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Give up on a hung run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Check every response beat that the table hands over.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_response(status, record_number, slot_index);
    end

    // Response side: stall in random bursts, never near the end of the run.
    initial
    begin
        int hold = 0;

        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (calm)
            begin
                rsp_ready <= 1'b1;
            end
            else if (hold > 0)
            begin
                hold--;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                rsp_ready <= 1'b0;
                hold = $urandom_range(0, 6);
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    // Present one request beat, called on a falling edge, and return on one.
    task send_request(logic [CMD_W-1:0] cmd, logic [DAY_W-1:0] d,
                      logic [MONTH_W-1:0] m, logic [KEY_W-1:0] y);
        req_valid <= 1'b1;
        command   <= cmd;
        day       <= d;
        month     <= m;
        year      <= y;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(cmd, d, m, y);
        sent++;
        calm = (sent >= CALM_FROM);
        @(negedge clk);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
    endtask

    // Fill the key pool; in a collision round every key lands on one residue.
    task fill_pool(int n, bit collide);
        logic [SLOT_W-1:0] residue;

        residue = SLOT_W'($urandom);
        for (int i = 0; i < n; i++)
        begin
            if (collide)
            begin
                pool_day[i]   = '0;
                pool_month[i] = '0;
                pool_year[i]  = {(KEY_W - SLOT_W)'($urandom_range(0, 1023)), residue};
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                pool_day[i]   = DAY_W'($urandom);
                pool_month[i] = MONTH_W'($urandom);
                pool_year[i]  = KEY_W'($urandom);
            end
            else
            begin
                pool_day[i]   = DAY_W'($urandom_range(0, 31));
                pool_month[i] = MONTH_W'($urandom_range(0, 12));
                pool_year[i]  = KEY_W'($urandom_range(0, 9999));
            end
        end
    endtask

    // Stimulus: directed cases, then random clear/insert/search rounds.
    initial
    begin
        int n_keys;
        int k;
        int r;

        wait (rst_n === 1'b1);
        @(negedge clk);

        // Search on an empty table, then a short probe chain on residue zero.
        send_request(CMD_SEARCH, 5'd0, 4'd0, 14'd0);
        send_request(CMD_INSERT, 5'd0, 4'd0, 14'd0);
        // Largest field values: the key sum wraps around the key width.
        send_request(CMD_INSERT, 5'd31, 4'd15, 14'd16383);
        send_request(CMD_SEARCH, 5'd31, 4'd15, 14'd16383);
        send_request(CMD_INSERT, 5'd0, 4'd0, 14'd16);
        send_request(CMD_INSERT, 5'd0, 4'd0, 14'd32);
        send_request(CMD_INSERT, 5'd0, 4'd0, 14'd48);
        // The chain of residue zero is full: no free slot.
        send_request(CMD_INSERT, 5'd0, 4'd0, 14'd64);
        // Every probed slot is taken by another key: not found after the probe limit.
        send_request(CMD_SEARCH, 5'd0, 4'd0, 14'd80);
        // A duplicate key; the search returns the first one probed.
        send_request(CMD_INSERT, 5'd1, 4'd0, 14'd44);
        send_request(CMD_SEARCH, 5'd2, 4'd1, 14'd42);
        send_request(CMD_SEARCH, 5'd0, 4'd0, 14'd48);
        send_request(CMD_UNUSED, 5'd31, 4'd15, 14'd16383);
        send_request(CMD_INSERT, 5'd31, 4'd12, 14'd9999);
        send_request(CMD_SEARCH, 5'd31, 4'd12, 14'd9999);
        send_request(CMD_CLEAR, 5'd31, 4'd15, 14'd16383);
        send_request(CMD_SEARCH, 5'd0, 4'd0, 14'd0);
        send_request(CMD_INSERT, 5'd21, 4'd10, 14'd10922);
        send_request(CMD_SEARCH, 5'd21, 4'd10, 14'd10922);
        send_request(CMD_UNUSED, 5'd0, 4'd0, 14'd0);

        while (sent < N_ITEMS)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                // Noise: any command and any field values.
                repeat ($urandom_range(1, 5))
                    send_request(CMD_W'($urandom), DAY_W'($urandom),
                                 MONTH_W'($urandom), KEY_W'($urandom));
            end
            else
            begin
                // A round starts from an empty table and works on a small key pool.
                send_request(CMD_CLEAR, DAY_W'($urandom), MONTH_W'($urandom),
                             KEY_W'($urandom));
                n_keys = $urandom_range(1, POOL_MAX);
                fill_pool(n_keys, $urandom_range(0, 2) == 0);
                repeat ($urandom_range(4, 30))
                begin
                    r = $urandom_range(0, 99);
                    k = $urandom_range(0, n_keys - 1);
                    if (r < 50)
                        send_request(CMD_INSERT, pool_day[k], pool_month[k], pool_year[k]);
                    else if (r < 90)
                        send_request(CMD_SEARCH, pool_day[k], pool_month[k], pool_year[k]);
                    else
                        send_request(CMD_SEARCH, DAY_W'($urandom), MONTH_W'($urandom),
                                     KEY_W'($urandom));
                end
            end
        end
        req_valid <= 1'b0;

        // Drain the outstanding answers, then allow for the longest operation.
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
